>>> rtl/rgbm_pkg.sv
// shared constants, types and helper functions of the rgb gray morphology block
package rgbm_pkg;

	// field widths of the channels and the configuration port
	localparam int unsigned CHAN_W       = 8;
	localparam int unsigned ROW_W        = 12;
	localparam int unsigned COL_W        = 11;
	localparam int unsigned WIDTH_REG_W  = 12;
	localparam int unsigned HEIGHT_REG_W = 13;
	localparam int unsigned CFG_DATA_W   = 13;
	localparam int unsigned CFG_INDEX_W  = 2;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_DILATE_MODE  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	// register reset values
	localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 12'd640;
	localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd480;

	// frame size arithmetic is done in this width, wide enough for any legal size
	localparam int unsigned SIZE_W   = 16;
	localparam int unsigned MIN_SIZE = 3;

	// divide by three: (sum * 683) >> 11 is exact for sums below 2048
	localparam int unsigned DIV3_RECIP = 683;
	localparam int unsigned DIV3_SHIFT = 11;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	// gray level of one pixel, rounded down
	function automatic logic [CHAN_W-1:0] gray_of(input pixel_t p);
		logic [9:0]  sum;
		logic [19:0] prod;
		sum  = 10'(p.red) + 10'(p.green) + 10'(p.blue);
		prod = 20'(sum) * 20'(DIV3_RECIP);
		return CHAN_W'(prod >> DIV3_SHIFT);
	endfunction

	// minimum for erosion, maximum for dilation
	function automatic logic [CHAN_W-1:0] pick(input logic [CHAN_W-1:0] a,
			input logic [CHAN_W-1:0] b, input logic dilate);
		if (dilate) begin
			return (a > b) ? a : b;
		end
		return (a < b) ? a : b;
	endfunction

	// row index modulo three, advanced by one row
	function automatic logic [1:0] next_bank(input logic [1:0] b);
		return (b == 2'd2) ? 2'd0 : b + 2'd1;
	endfunction

endpackage

>>> rtl/rgbm_pixel_if.sv
// input pixel channel with valid / ready handshake
interface rgbm_pixel_if;
	logic                       valid;
	logic                       ready;
	logic [rgbm_pkg::CHAN_W-1:0] red;
	logic [rgbm_pkg::CHAN_W-1:0] green;
	logic [rgbm_pkg::CHAN_W-1:0] blue;
	logic                       frame_start;

	modport source (output valid, output red, output green, output blue,
		output frame_start, input ready);
	modport sink (input valid, input red, input green, input blue,
		input frame_start, output ready);
endinterface

>>> rtl/rgbm_result_if.sv
// result pixel channel with valid / ready handshake
interface rgbm_result_if;
	logic                        valid;
	logic                        ready;
	logic [rgbm_pkg::CHAN_W-1:0] out_red;
	logic [rgbm_pkg::CHAN_W-1:0] out_green;
	logic [rgbm_pkg::CHAN_W-1:0] out_blue;
	logic [rgbm_pkg::ROW_W-1:0]  out_row;
	logic [rgbm_pkg::COL_W-1:0]  out_col;
	logic                        last_of_run;
	logic                        frame_done;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output out_row, output out_col, output last_of_run, output frame_done,
		input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input out_row, input out_col, input last_of_run, input frame_done,
		output ready);
endinterface

>>> rtl/rgb_gray_morphology_3x3_unit.sv
// streaming 3x3 gray erosion / dilation over an rgb raster with a three-row line store
//
//  channel   direction  handshake          payload
//  pix       in         valid / ready      red, green, blue, frame_start
//  res       out        valid / ready      out_red/green/blue, out_row, out_col,
//                                          last_of_run, frame_done
//  cfg       in         cfg_we, no wait    cfg_index, cfg_data
//
// one pixel per clock while res does not stall and each pixel yields at most one
// result; a pixel yielding k results (two at a row end and on the last row, four
// for the bottom-right pixel) holds the input until the single result register has
// taken all k. the line store is three single-port-read banks, one per row modulo
// three, read at the pixel's column when it is taken; it needs no clearing. arst_n
// clears all but the data registers; a stall on res holds the result register and
// backs up into pix only when the stage-1 item is still busy.
module rgb_gray_morphology_3x3_unit #(
	parameter int unsigned MAX_WIDTH  = 2048,
	parameter int unsigned MAX_HEIGHT = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	rgbm_pixel_if.sink                         pix,
	rgbm_result_if.source                      res,
	input  logic                               cfg_we,
	input  logic [rgbm_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [rgbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int unsigned CW = $clog2(MAX_WIDTH);
	localparam int unsigned RW = $clog2(MAX_HEIGHT);
	localparam int unsigned SW = rgbm_pkg::SIZE_W;
	localparam int unsigned GW = rgbm_pkg::CHAN_W;

	// one bit per result a pixel can cause, in emission order
	localparam logic [3:0] EMIT_CENTER   = 4'b0001;
	localparam logic [3:0] EMIT_ROW_END  = 4'b0010;
	localparam logic [3:0] EMIT_LAST_ROW = 4'b0100;
	localparam logic [3:0] EMIT_CORNER   = 4'b1000;

	// configuration registers
	logic                                 dilate_q;
	logic [rgbm_pkg::WIDTH_REG_W-1:0]     width_q;
	logic [rgbm_pkg::HEIGHT_REG_W-1:0]    height_q;

	// input position
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [1:0]    bank_q;

	// stage 1
	logic              valid_s1;
	logic [3:0]        pend_s1;
	rgbm_pkg::pixel_t  pix_s1;
	logic [GW-1:0]     gray_s1;
	logic [RW-1:0]     row_s1;
	logic [CW-1:0]     col_s1;
	logic [1:0]        bank_s1;
	logic              inner_s1;
	rgbm_pkg::pixel_t  rd_s1 [3];

	// line store
	rgbm_pkg::pixel_t  row_mem [3][MAX_WIDTH];

	// previous two columns of the window, minimum and maximum of each
	logic [GW-1:0]     colx1_lo_q;
	logic [GW-1:0]     colx2_lo_q;
	logic [GW-1:0]     colx1_hi_q;
	logic [GW-1:0]     colx2_hi_q;
	rgbm_pkg::pixel_t  prev_mid_q;
	rgbm_pkg::pixel_t  prev_cur_q;

	// result register
	logic              out_valid_q;
	rgbm_pkg::pixel_t  out_pix_q;
	logic [rgbm_pkg::ROW_W-1:0] out_row_q;
	logic [rgbm_pkg::COL_W-1:0] out_col_q;
	logic              out_last_q;
	logic              out_done_q;

	logic [SW-1:0]     w_wide;
	logic [SW-1:0]     h_wide;
	logic [CW:0]       w_eff;
	logic [RW:0]       h_eff;
	logic [CW:0]       c_tmp;
	logic [RW:0]       r_tmp;
	logic [1:0]        b_tmp;
	logic [CW:0]       c_nx;
	logic [RW:0]       r_nx;
	logic [1:0]        b_nx;
	logic [CW-1:0]     c_in;
	logic [RW-1:0]     r_in;
	logic [3:0]        flags_in;
	logic              inner_in;
	rgbm_pkg::pixel_t  pix_in;
	logic              pix_take;
	logic              out_free;
	logic              load;
	logic              retire;
	logic [3:0]        first;
	logic [3:0]        pend_rest;
	rgbm_pkg::pixel_t  mid_pix;
	rgbm_pkg::pixel_t  top_pix;
	logic [GW-1:0]     colx_lo;
	logic [GW-1:0]     colx_hi;
	logic [GW-1:0]     win_lo;
	logic [GW-1:0]     win_hi;
	logic [GW-1:0]     win_x;
	rgbm_pkg::pixel_t  sel_pix;
	logic [RW-1:0]     sel_row;
	logic [CW-1:0]     sel_col;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dilate_q <= 1'b0;
			width_q  <= rgbm_pkg::RESET_WIDTH;
			height_q <= rgbm_pkg::RESET_HEIGHT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rgbm_pkg::REG_DILATE_MODE:  dilate_q <= cfg_data[0];
				rgbm_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data[rgbm_pkg::WIDTH_REG_W-1:0];
				rgbm_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// frame size saturated to the legal range
	always_comb begin
		w_wide = SW'(width_q);
		if (w_wide < SW'(rgbm_pkg::MIN_SIZE)) begin
			w_wide = SW'(rgbm_pkg::MIN_SIZE);
		end else if (w_wide > SW'(MAX_WIDTH)) begin
			w_wide = SW'(MAX_WIDTH);
		end
		h_wide = SW'(height_q);
		if (h_wide < SW'(rgbm_pkg::MIN_SIZE)) begin
			h_wide = SW'(rgbm_pkg::MIN_SIZE);
		end else if (h_wide > SW'(MAX_HEIGHT)) begin
			h_wide = SW'(MAX_HEIGHT);
		end
		w_eff = (CW+1)'(w_wide);
		h_eff = (RW+1)'(h_wide);
	end

	// position of the incoming pixel and of the one after it
	always_comb begin
		c_tmp = {1'b0, col_q};
		r_tmp = {1'b0, row_q};
		b_tmp = bank_q;
		if (pix.frame_start) begin
			c_tmp = '0;
			r_tmp = '0;
			b_tmp = '0;
		end else begin
			if (c_tmp >= w_eff) begin
				c_tmp = '0;
				r_tmp = r_tmp + 1'b1;
				b_tmp = rgbm_pkg::next_bank(b_tmp);
			end
			if (r_tmp >= h_eff) begin
				r_tmp = '0;
				b_tmp = '0;
			end
		end
		c_in = c_tmp[CW-1:0];
		r_in = r_tmp[RW-1:0];
		c_nx = c_tmp + 1'b1;
		r_nx = r_tmp;
		b_nx = b_tmp;
		if (c_nx >= w_eff) begin
			c_nx = '0;
			r_nx = r_tmp + 1'b1;
			b_nx = rgbm_pkg::next_bank(b_tmp);
			if (r_nx >= h_eff) begin
				r_nx = '0;
				b_nx = '0;
			end
		end
	end

	// which results this pixel causes
	always_comb begin
		flags_in[0] = (r_in != '0) && (c_in != '0);
		flags_in[1] = (r_in != '0) && ({1'b0, c_in} == w_eff - 1'b1);
		flags_in[2] = ({1'b0, r_in} == h_eff - 1'b1) && (c_in != '0);
		flags_in[3] = ({1'b0, r_in} == h_eff - 1'b1) && ({1'b0, c_in} == w_eff - 1'b1);
		inner_in    = (r_in >= RW'(2)) && (c_in >= CW'(2));
	end

	assign pix_in.red   = pix.red;
	assign pix_in.green = pix.green;
	assign pix_in.blue  = pix.blue;

	// handshake
	assign out_free  = !out_valid_q || res.ready;
	assign first     = pend_s1 & (~pend_s1 + 4'd1);
	assign pend_rest = pend_s1 & ~first;
	assign load      = valid_s1 && (pend_s1 != '0) && out_free;
	assign retire    = valid_s1 && ((pend_s1 == '0) || (load && (pend_rest == '0)));
	assign pix.ready = !valid_s1 || retire;
	assign pix_take  = pix.valid && pix.ready;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			bank_q <= '0;
		end else if (pix_take) begin
			col_q  <= c_nx[CW-1:0];
			row_q  <= r_nx[RW-1:0];
			bank_q <= b_nx;
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pend_s1  <= '0;
		end else begin
			if (pix_take) begin
				valid_s1 <= 1'b1;
				pend_s1  <= flags_in;
			end else begin
				if (retire) begin
					valid_s1 <= 1'b0;
				end
				if (load) begin
					pend_s1 <= pend_rest;
				end
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (pix_take) begin
			pix_s1   <= pix_in;
			gray_s1  <= rgbm_pkg::gray_of(pix_in);
			row_s1   <= r_in;
			col_s1   <= c_in;
			bank_s1  <= b_tmp;
			inner_s1 <= inner_in;
		end
	end

	// line store: write the pixel, read the two rows above at its column
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			if (pix_take) begin
				if (b_tmp == 2'(k)) begin
					row_mem[k][c_in] <= pix_in;
				end
				rd_s1[k] <= row_mem[k][c_in];
			end
		end
	end

	// pick the rows r-1 and r-2 out of the three banks
	always_comb begin
		case (bank_s1)
			2'd0: begin
				mid_pix = rd_s1[2];
				top_pix = rd_s1[1];
			end
			2'd1: begin
				mid_pix = rd_s1[0];
				top_pix = rd_s1[2];
			end
			2'd2: begin
				mid_pix = rd_s1[1];
				top_pix = rd_s1[0];
			end
			default: begin
				mid_pix = rd_s1[0];
				top_pix = rd_s1[1];
			end
		endcase
	end

	// column minimum and maximum, then the window extreme over three columns
	assign colx_lo = rgbm_pkg::pick(rgbm_pkg::pick(gray_s1, rgbm_pkg::gray_of(mid_pix),
		1'b0), rgbm_pkg::gray_of(top_pix), 1'b0);
	assign colx_hi = rgbm_pkg::pick(rgbm_pkg::pick(gray_s1, rgbm_pkg::gray_of(mid_pix),
		1'b1), rgbm_pkg::gray_of(top_pix), 1'b1);
	assign win_lo  = rgbm_pkg::pick(rgbm_pkg::pick(colx_lo, colx1_lo_q, 1'b0), colx2_lo_q,
		1'b0);
	assign win_hi  = rgbm_pkg::pick(rgbm_pkg::pick(colx_hi, colx1_hi_q, 1'b1), colx2_hi_q,
		1'b1);
	assign win_x   = dilate_q ? win_hi : win_lo;

	// shift the window one column once the item is finished
	always_ff @(posedge clk) begin
		if (retire) begin
			colx1_lo_q <= colx_lo;
			colx2_lo_q <= colx1_lo_q;
			colx1_hi_q <= colx_hi;
			colx2_hi_q <= colx1_hi_q;
			prev_mid_q <= mid_pix;
			prev_cur_q <= pix_s1;
		end
	end

	// select the next pending result
	always_comb begin
		case (first)
			EMIT_CENTER: begin
				if (inner_s1) begin
					sel_pix.red   = win_x;
					sel_pix.green = win_x;
					sel_pix.blue  = win_x;
				end else begin
					sel_pix = prev_mid_q;
				end
				sel_row = row_s1 - 1'b1;
				sel_col = col_s1 - 1'b1;
			end
			EMIT_ROW_END: begin
				sel_pix = mid_pix;
				sel_row = row_s1 - 1'b1;
				sel_col = col_s1;
			end
			EMIT_LAST_ROW: begin
				sel_pix = prev_cur_q;
				sel_row = row_s1;
				sel_col = col_s1 - 1'b1;
			end
			default: begin
				sel_pix = pix_s1;
				sel_row = row_s1;
				sel_col = col_s1;
			end
		endcase
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= load;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_pix_q  <= sel_pix;
			out_row_q  <= rgbm_pkg::ROW_W'(sel_row);
			out_col_q  <= rgbm_pkg::COL_W'(sel_col);
			out_last_q <= (pend_rest == '0);
			out_done_q <= (first == EMIT_CORNER);
		end
	end

	assign res.valid       = out_valid_q;
	assign res.out_red     = out_pix_q.red;
	assign res.out_green   = out_pix_q.green;
	assign res.out_blue    = out_pix_q.blue;
	assign res.out_row     = out_row_q;
	assign res.out_col     = out_col_q;
	assign res.last_of_run = out_last_q;
	assign res.frame_done  = out_done_q;

	// checks
	a_pend_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> pend_s1 == '0)
		else $error("results pending with no item in stage 1");

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (!res.frame_done || res.last_of_run))
		else $error("frame end result is not the last of its run");

	a_take_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		pix_take |=> valid_s1)
		else $error("taken item did not reach stage 1");

	a_retire_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && !pix_take) |=> !valid_s1)
		else $error("finished item still held in stage 1");

endmodule

>>> sim/tb_top.sv
// testbench of rgb_gray_morphology_3x3_unit: directed and random pixel streams checked by a predictor
`timescale 1ns / 100ps

module tb_top;

	localparam int unsigned MAX_W         = 2048;
	localparam int unsigned MAX_H         = 4096;
	localparam int unsigned IDLE_PCT      = 38;
	localparam int unsigned SETTLE_CYCLES = 8;
	localparam int unsigned DRAIN_LIMIT   = 20000;
	localparam int unsigned RANDOM_ITEMS  = 225;

	typedef struct packed {
		rgbm_pkg::pixel_t px;
		logic             frame_start;
	} pix_item_t;

	typedef struct packed {
		logic [rgbm_pkg::CHAN_W-1:0] red;
		logic [rgbm_pkg::CHAN_W-1:0] green;
		logic [rgbm_pkg::CHAN_W-1:0] blue;
		logic [rgbm_pkg::ROW_W-1:0]  row;
		logic [rgbm_pkg::COL_W-1:0]  col;
		logic                        last;
		logic                        done;
	} result_t;

	// one row of the directed stimulus: a register write or a pixel
	typedef struct {
		bit                               is_reg;
		logic [rgbm_pkg::CFG_INDEX_W-1:0] index;
		logic [rgbm_pkg::CFG_DATA_W-1:0]  data;
		pix_item_t                        item;
		bit                               typed;
		result_t                          typed_res;
	} dir_step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [rgbm_pkg::CFG_INDEX_W-1:0] cfg_index;
	logic [rgbm_pkg::CFG_DATA_W-1:0]  cfg_data;

	rgbm_pixel_if  pix_ch ();
	rgbm_result_if res_ch ();

	rgb_gray_morphology_3x3_unit #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model state: registers, position and the three-row line store
	logic                              dilate     = 1'b0;
	logic [rgbm_pkg::WIDTH_REG_W-1:0]  width_reg  = rgbm_pkg::RESET_WIDTH;
	logic [rgbm_pkg::HEIGHT_REG_W-1:0] height_reg = rgbm_pkg::RESET_HEIGHT;
	int unsigned                       pos_row    = 0;
	int unsigned                       pos_col    = 0;
	rgbm_pkg::pixel_t                  line_store [0:3*MAX_W-1];

	result_t     due_pixels [$];
	int unsigned mismatches = 0;
	int unsigned items_sent = 0;
	bit          quiet      = 1'b0;
	dir_step_t   directed_steps [$];

	always #1 clk = ~clk;

	function automatic int unsigned clamp_size(input int unsigned v, input int unsigned hi);
		if (v < rgbm_pkg::MIN_SIZE) begin
			return rgbm_pkg::MIN_SIZE;
		end
		return (v > hi) ? hi : v;
	endfunction

	// append to the queue of results still to come
	function automatic void queue_due(input result_t r);
		due_pixels.insert(due_pixels.size(), r);
	endfunction

	// append one row to the directed stimulus
	function automatic void add_step(input dir_step_t s);
		directed_steps.insert(directed_steps.size(), s);
	endfunction

	// result pixel at one position: window extreme inside, the stored pixel on the border
	function automatic result_t result_at(input int unsigned row, input int unsigned col,
			input int unsigned w, input int unsigned h);
		result_t          res;
		rgbm_pkg::pixel_t p;
		int unsigned      g;
		int unsigned      best;
		p = line_store[(row % 3) * MAX_W + col];
		res.red   = p.red;
		res.green = p.green;
		res.blue  = p.blue;
		if (row >= 1 && row + 1 < h && col >= 1 && col + 1 < w) begin
			best = 0;
			for (int unsigned dy = 0; dy < 3; dy++) begin
				for (int unsigned dx = 0; dx < 3; dx++) begin
					p = line_store[((row - 1 + dy) % 3) * MAX_W + col - 1 + dx];
					g = (32'(p.red) + 32'(p.green) + 32'(p.blue)) / 3;
					if (dy == 0 && dx == 0) begin
						best = g;
					end else if (dilate ? (g > best) : (g < best)) begin
						best = g;
					end
				end
			end
			res.red   = rgbm_pkg::CHAN_W'(best);
			res.green = rgbm_pkg::CHAN_W'(best);
			res.blue  = rgbm_pkg::CHAN_W'(best);
		end
		res.row  = rgbm_pkg::ROW_W'(row);
		res.col  = rgbm_pkg::COL_W'(col);
		res.last = 1'b0;
		res.done = (row == h - 1 && col == w - 1);
		return res;
	endfunction

	// store one pixel, work out the results it releases and advance the position
	function automatic void filter_pixel(input pix_item_t it, output result_t outs[$]);
		int unsigned w;
		int unsigned h;
		int unsigned r;
		int unsigned c;
		w = clamp_size(32'(width_reg), MAX_W);
		h = clamp_size(32'(height_reg), MAX_H);
		outs.delete();
		if (it.frame_start) begin
			r = 0;
			c = 0;
		end else begin
			r = pos_row;
			c = pos_col;
			if (c >= w) begin
				c = 0;
				r++;
			end
			if (r >= h) begin
				r = 0;
			end
		end
		line_store[(r % 3) * MAX_W + c] = it.px;
		if (r >= 1 && c >= 1) outs.insert(outs.size(), result_at(r - 1, c - 1, w, h));
		if (r >= 1 && c == w - 1) outs.insert(outs.size(), result_at(r - 1, w - 1, w, h));
		if (r == h - 1 && c >= 1) outs.insert(outs.size(), result_at(r, c - 1, w, h));
		if (r == h - 1 && c == w - 1) outs.insert(outs.size(), result_at(r, w - 1, w, h));
		if (outs.size() > 0) begin
			outs[outs.size() - 1].last = 1'b1;
		end
		c++;
		if (c >= w) begin
			c = 0;
			r++;
			if (r >= h) begin
				r = 0;
			end
		end
		pos_row = r;
		pos_col = c;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got, input result_t ctx);
		if (got !== want) begin
			$display("%0t: %s of row %0d col %0d: expected %0d, actual %0d",
				$time, name, ctx.row, ctx.col, want, got);
			mismatches++;
		end
	endfunction

	function automatic logic [rgbm_pkg::CHAN_W-1:0] random_channel();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return rgbm_pkg::CHAN_W'($urandom_range(255));
		endcase
	endfunction

	function automatic dir_step_t reg_row(input logic [rgbm_pkg::CFG_INDEX_W-1:0] index,
			input int unsigned data);
		dir_step_t s;
		s        = '{default: '0};
		s.is_reg = 1'b1;
		s.index  = index;
		s.data   = rgbm_pkg::CFG_DATA_W'(data);
		return s;
	endfunction

	function automatic dir_step_t pixel_row(input int unsigned r, input int unsigned g,
			input int unsigned b, input bit fs);
		dir_step_t s;
		s                  = '{default: '0};
		s.item.px.red      = rgbm_pkg::CHAN_W'(r);
		s.item.px.green    = rgbm_pkg::CHAN_W'(g);
		s.item.px.blue     = rgbm_pkg::CHAN_W'(b);
		s.item.frame_start = fs;
		return s;
	endfunction

	// pixel whose single result is known by hand: the stored pixel at a border position
	function automatic dir_step_t typed_row(input int unsigned r, input int unsigned g,
			input int unsigned b, input bit fs, input int unsigned er, input int unsigned eg,
			input int unsigned eb, input int unsigned row, input int unsigned col);
		dir_step_t s;
		s                   = pixel_row(r, g, b, fs);
		s.typed             = 1'b1;
		s.typed_res.red     = rgbm_pkg::CHAN_W'(er);
		s.typed_res.green   = rgbm_pkg::CHAN_W'(eg);
		s.typed_res.blue    = rgbm_pkg::CHAN_W'(eb);
		s.typed_res.row     = rgbm_pkg::ROW_W'(row);
		s.typed_res.col     = rgbm_pkg::COL_W'(col);
		s.typed_res.last    = 1'b1;
		s.typed_res.done    = 1'b0;
		return s;
	endfunction

	// hold off the input until every result is out, then let the pipeline settle
	task automatic drain_results(input int unsigned limit);
		int unsigned waited;
		waited = 0;
		pix_ch.valid <= 1'b0;
		while (due_pixels.size() != 0 && waited < limit) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rgbm_pkg::CFG_INDEX_W-1:0] index,
			input logic [rgbm_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (index)
			rgbm_pkg::REG_DILATE_MODE:  dilate     = data[0];
			rgbm_pkg::REG_IMAGE_WIDTH:  width_reg  = data[rgbm_pkg::WIDTH_REG_W-1:0];
			rgbm_pkg::REG_IMAGE_HEIGHT: height_reg = data[rgbm_pkg::HEIGHT_REG_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// offer one item, wait for the handshake, then queue what it releases
	task automatic send_pixel(input pix_item_t it, input bit typed, input result_t typed_res);
		result_t outs [$];
		if (!quiet && $urandom_range(99) < IDLE_PCT) begin
			pix_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
		end
		pix_ch.valid       <= 1'b1;
		pix_ch.red         <= it.px.red;
		pix_ch.green       <= it.px.green;
		pix_ch.blue        <= it.px.blue;
		pix_ch.frame_start <= it.frame_start;
		do @(posedge clk); while (!pix_ch.ready);
		filter_pixel(it, outs);
		if (typed) begin
			queue_due(typed_res);
		end else begin
			foreach (outs[i]) queue_due(outs[i]);
		end
		items_sent++;
		quiet = (items_sent >= 125 && items_sent < 195);
	endtask

	// result side: check each accepted item against the oldest due pixel, stall at random
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (due_pixels.size() == 0) begin
					$display("%0t: unexpected result, row %0d col %0d", $time,
						res_ch.out_row, res_ch.out_col);
					mismatches++;
				end else begin
					want = due_pixels.pop_front();
					check_field("red", 32'(want.red), 32'(res_ch.out_red), want);
					check_field("green", 32'(want.green), 32'(res_ch.out_green), want);
					check_field("blue", 32'(want.blue), 32'(res_ch.out_blue), want);
					check_field("row", 32'(want.row), 32'(res_ch.out_row), want);
					check_field("col", 32'(want.col), 32'(res_ch.out_col), want);
					check_field("last_of_run", 32'(want.last), 32'(res_ch.last_of_run),
						want);
					check_field("frame_done", 32'(want.done), 32'(res_ch.frame_done), want);
				end
			end
			res_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
		end else begin
			res_ch.ready <= 1'b0;
		end
	end

	initial begin
		#1_000_000;
		$display("FAIL");
		$finish;
	end

	// stimulus
	initial begin
		pix_item_t   it;
		result_t     no_res;
		int unsigned random_target;
		int unsigned n;
		int unsigned new_w;
		bit          force_fs;

		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_data           = '0;
		pix_ch.valid       = 1'b0;
		pix_ch.red         = '0;
		pix_ch.green       = '0;
		pix_ch.blue        = '0;
		pix_ch.frame_start = 1'b0;
		no_res             = '0;

		// erosion on a 3x3 frame opened by frame_start
		add_step(reg_row(rgbm_pkg::REG_IMAGE_WIDTH, 3));
		add_step(reg_row(rgbm_pkg::REG_IMAGE_HEIGHT, 3));
		add_step(pixel_row(255, 255, 255, 1));
		add_step(pixel_row(0, 0, 0, 0));
		add_step(pixel_row(128, 64, 32, 0));
		add_step(pixel_row(1, 2, 3, 0));
		add_step(typed_row(200, 100, 50, 0, 255, 255, 255, 0, 0));
		add_step(pixel_row(17, 34, 68, 0));
		add_step(pixel_row(255, 0, 255, 0));
		add_step(pixel_row(90, 180, 45, 0));
		add_step(pixel_row(250, 250, 250, 0));
		// dilation, sizes below the minimum, next frame follows the wrap with no frame_start
		add_step(reg_row(rgbm_pkg::REG_DILATE_MODE, 1));
		add_step(reg_row(rgbm_pkg::REG_IMAGE_WIDTH, 2));
		add_step(reg_row(rgbm_pkg::REG_IMAGE_HEIGHT, 0));
		add_step(pixel_row(0, 0, 0, 0));
		add_step(pixel_row(255, 255, 255, 0));
		add_step(pixel_row(85, 170, 0, 0));
		add_step(pixel_row(12, 240, 99, 0));
		add_step(typed_row(3, 3, 3, 0, 0, 0, 0, 0, 0));
		add_step(pixel_row(254, 253, 252, 0));
		add_step(pixel_row(170, 85, 255, 0));
		add_step(pixel_row(0, 255, 0, 0));
		add_step(pixel_row(127, 128, 129, 0));
		// sizes above the maximum, then a width cut that moves the column past the row end
		add_step(reg_row(rgbm_pkg::REG_IMAGE_WIDTH, 4095));
		add_step(reg_row(rgbm_pkg::REG_IMAGE_HEIGHT, 8191));
		add_step(pixel_row(10, 20, 30, 1));
		add_step(pixel_row(40, 50, 60, 0));
		add_step(pixel_row(70, 80, 90, 0));
		add_step(reg_row(rgbm_pkg::REG_IMAGE_WIDTH, 3));
		add_step(pixel_row(100, 110, 120, 0));
		add_step(typed_row(130, 140, 150, 0, 10, 20, 30, 0, 0));
		add_step(pixel_row(160, 170, 180, 0));
		add_step(pixel_row(190, 200, 210, 0));

		// reset
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_reg) begin
				drain_results(DRAIN_LIMIT);
				write_reg(directed_steps[i].index, directed_steps[i].data);
			end else begin
				send_pixel(directed_steps[i].item, directed_steps[i].typed,
					directed_steps[i].typed_res);
			end
		end

		// random part: runs of raster pixels under changing settings
		random_target = items_sent + RANDOM_ITEMS;
		while (items_sent < random_target) begin
			drain_results(DRAIN_LIMIT);
			force_fs = 1'b0;
			if ($urandom_range(3) == 0) begin
				write_reg(rgbm_pkg::REG_DILATE_MODE,
					rgbm_pkg::CFG_DATA_W'($urandom_range(1)));
			end
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(19))
					0: new_w = $urandom_range(2);
					1: new_w = MAX_W;
					2: new_w = 4095;
					3: new_w = $urandom_range(4095);
					default: new_w = $urandom_range(10, 3);
				endcase
				// a wider row mid-frame would read line store entries never written
				if (clamp_size(new_w, MAX_W) > clamp_size(32'(width_reg), MAX_W) &&
						(pos_row != 0 || pos_col != 0)) begin
					force_fs = 1'b1;
				end
				write_reg(rgbm_pkg::REG_IMAGE_WIDTH, rgbm_pkg::CFG_DATA_W'(new_w));
			end
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(19))
					0: write_reg(rgbm_pkg::REG_IMAGE_HEIGHT,
						rgbm_pkg::CFG_DATA_W'($urandom_range(2)));
					1: write_reg(rgbm_pkg::REG_IMAGE_HEIGHT, rgbm_pkg::CFG_DATA_W'(MAX_H));
					2: write_reg(rgbm_pkg::REG_IMAGE_HEIGHT, rgbm_pkg::CFG_DATA_W'(8191));
					3: write_reg(rgbm_pkg::REG_IMAGE_HEIGHT,
						rgbm_pkg::CFG_DATA_W'($urandom_range(8191)));
					default: write_reg(rgbm_pkg::REG_IMAGE_HEIGHT,
						rgbm_pkg::CFG_DATA_W'($urandom_range(8, 3)));
				endcase
			end
			// wide rows get short runs, narrow ones long enough to wrap frames
			if (clamp_size(32'(width_reg), MAX_W) > 16) begin
				n = $urandom_range(24, 8);
			end else begin
				n = $urandom_range(48, 6);
			end
			if (n > random_target - items_sent) begin
				n = random_target - items_sent;
			end
			for (int unsigned k = 0; k < n; k++) begin
				it.px.red      = random_channel();
				it.px.green    = random_channel();
				it.px.blue     = random_channel();
				it.frame_start = (k == 0 && (force_fs || $urandom_range(9) == 0)) ||
					($urandom_range(49) == 0);
				send_pixel(it, 1'b0, no_res);
			end
		end

		// wait out the last results
		drain_results(DRAIN_LIMIT);
		if (due_pixels.size() != 0) begin
			$display("%0t: %0d result pixels never arrived", $time, due_pixels.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

>>> rgb_gray_morphology_3x3_unit.f
rtl/rgbm_pkg.sv
rtl/rgbm_pixel_if.sv
rtl/rgbm_result_if.sv
rtl/rgb_gray_morphology_3x3_unit.sv
sim/tb_top.sv
